FILE: hdl/mvn_pkg.sv
// Shared widths, constants and controller/datapath interface types for the matrix-vector norm.
package mvn_pkg;

    // Field widths
    localparam int unsigned ELEM_W     = 16;  // Q1.15 matrix and vector elements
    localparam int unsigned PROD_W     = 32;  // Q2.30 product
    localparam int unsigned DIM_W      = 11;  // dimension register
    localparam int unsigned ROW_SUM_W  = 42;  // row dot product accumulator
    localparam int unsigned FRAC_W     = 15;  // bits dropped at row end
    localparam int unsigned ROW_VAL_W  = ROW_SUM_W - FRAC_W;  // 27-bit row value
    localparam int unsigned SQ_W       = 2 * ROW_VAL_W;       // square of the magnitude
    localparam int unsigned SQ_SUM_W   = 64;  // saturating sum of squares
    localparam int unsigned NORM_W     = 32;  // integer square root

    // Square root unit: one result bit per cycle
    localparam int unsigned SQRT_STEPS = SQ_SUM_W / 2;
    localparam int unsigned STEP_W     = $clog2(SQRT_STEPS);

    // Dimension register value after reset
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1000);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear;       // drop all accumulators and pipeline contents
        logic acc_valid;   // an input beat is taken this cycle
        logic use_prod;    // dimension above one: accumulate products
        logic row_end;     // this beat closes a row
        logic root_start;  // load the square root unit from the sum of squares
        logic root_step;   // one square root iteration
        logic load_out;    // move the root into the output register
    } mvn_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pipe_busy;   // products or squares still in flight
        logic out_free;    // output register can take a result this cycle
    } mvn_status_t;

endpackage

FILE: hdl/mvn_ctrl.sv
// Controller: dimension register, row/column counters and the sequencing state machine.
module mvn_ctrl #(
    parameter int unsigned MAX_DIMENSION = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_enable,
    input  logic [mvn_pkg::DIM_W-1:0]       cfg_write_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  mvn_pkg::mvn_status_t            status,
    output mvn_pkg::mvn_cmd_t               cmd
);

    localparam int unsigned CNT_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
    localparam logic [mvn_pkg::DIM_W-1:0] MAX_D = mvn_pkg::DIM_W'(MAX_DIMENSION);
    localparam logic [mvn_pkg::DIM_W-1:0] ONE_D = mvn_pkg::DIM_W'(1);
    localparam logic [mvn_pkg::STEP_W-1:0] LAST_STEP =
        mvn_pkg::STEP_W'(mvn_pkg::SQRT_STEPS - 1);

    typedef enum logic [3:0] {
        ST_ACCUM = 4'b0001,
        ST_FLUSH = 4'b0010,
        ST_ROOT  = 4'b0100,
        ST_LOAD  = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [mvn_pkg::DIM_W-1:0]    dim_reg;
    logic [CNT_W-1:0]             col_reg, col_next;
    logic [CNT_W-1:0]             row_reg, row_next;
    logic [mvn_pkg::STEP_W-1:0]   step_reg, step_next;

    logic [mvn_pkg::DIM_W-1:0]    dim_act;
    logic                         accept;
    logic                         col_last;
    logic                         row_last;

    // Active dimension: zero counts as one, large values clamp to the maximum
    always_comb
    begin
        if (dim_reg == '0)
            dim_act = ONE_D;
        else if (dim_reg > MAX_D)
            dim_act = MAX_D;
        else
            dim_act = dim_reg;
    end

    assign in_stall = (state_reg != ST_ACCUM);
    assign accept   = in_valid && !in_stall;
    assign col_last = !((mvn_pkg::DIM_W'(col_reg) + ONE_D) < dim_act);
    assign row_last = !((mvn_pkg::DIM_W'(row_reg) + ONE_D) < dim_act);

    // Next state, counters and commands
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        step_next  = step_reg;

        cmd            = '0;
        cmd.clear      = cfg_write_enable;
        cmd.acc_valid  = accept;
        cmd.use_prod   = (dim_act > ONE_D);
        cmd.row_end    = col_last;

        unique case (state_reg)
            ST_ACCUM:
            begin
                if (accept)
                begin
                    if (col_last)
                    begin
                        col_next = '0;
                        if (row_last)
                        begin
                            row_next   = '0;
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                // Wait for the last square to land in the sum
                if (!status.pipe_busy)
                begin
                    cmd.root_start = 1'b1;
                    step_next      = '0;
                    state_next     = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase

        // A dimension write restarts the matrix
        if (cfg_write_enable)
        begin
            state_next = ST_ACCUM;
            col_next   = '0;
            row_next   = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            dim_reg   <= mvn_pkg::DIM_RESET;
            col_reg   <= '0;
            row_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            step_reg  <= step_next;
            if (cfg_write_enable)
                dim_reg <= cfg_write_data;
        end
    end

endmodule

FILE: hdl/mvn_dp.sv
// Datapath: product/accumulate pipeline, saturating square sum, square root unit, output register.
module mvn_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mvn_pkg::mvn_cmd_t                   cmd,
    output mvn_pkg::mvn_status_t                status,
    input  logic signed [mvn_pkg::ELEM_W-1:0]   matrix_value,
    input  logic signed [mvn_pkg::ELEM_W-1:0]   vector_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mvn_pkg::NORM_W-1:0]          norm,
    output logic                                saturated
);

    localparam logic [mvn_pkg::SQ_SUM_W-1:0] ROOT_BIT_INIT =
        mvn_pkg::SQ_SUM_W'(1) << (mvn_pkg::SQ_SUM_W - 2);

    // Pipeline valids
    logic s1_valid_reg, s1_row_end_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;

    // Arithmetic state
    logic signed [mvn_pkg::PROD_W-1:0]     prod_reg;
    logic signed [mvn_pkg::ROW_SUM_W-1:0]  row_sum_reg;
    logic signed [mvn_pkg::ROW_VAL_W-1:0]  row_val_reg;
    logic [mvn_pkg::SQ_W-1:0]              sq_reg;
    logic [mvn_pkg::SQ_SUM_W-1:0]          sq_sum_reg;
    logic                                  overflow_reg;

    // Square root unit
    logic [mvn_pkg::SQ_SUM_W-1:0]          root_work_reg;
    logic [mvn_pkg::SQ_SUM_W-1:0]          root_res_reg;
    logic [mvn_pkg::SQ_SUM_W-1:0]          root_bit_reg;
    logic                                  sat_cap_reg;

    // Output register
    logic [mvn_pkg::NORM_W-1:0]            norm_reg;
    logic                                  saturated_reg;

    logic signed [mvn_pkg::ROW_SUM_W-1:0]  row_sum_new;
    logic [mvn_pkg::ROW_VAL_W-1:0]         row_mag;
    logic [mvn_pkg::SQ_SUM_W:0]            sq_sum_wide;
    logic [mvn_pkg::SQ_SUM_W-1:0]          root_trial;
    logic                                  root_fits;

    // Row sum with the product in flight, sign extended to the accumulator
    assign row_sum_new = row_sum_reg
        + {{(mvn_pkg::ROW_SUM_W - mvn_pkg::PROD_W){prod_reg[mvn_pkg::PROD_W-1]}}, prod_reg};

    // Magnitude of the floored row value; the most negative value maps to 2^26
    assign row_mag = row_val_reg[mvn_pkg::ROW_VAL_W-1]
        ? (~row_val_reg + 1'b1) : row_val_reg;

    assign sq_sum_wide = {1'b0, sq_sum_reg} + (mvn_pkg::SQ_SUM_W + 1)'(sq_reg);

    // Digit-by-digit root trial subtract
    assign root_trial = root_res_reg + root_bit_reg;
    assign root_fits  = (root_work_reg >= root_trial);

    assign status.pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign norm      = norm_reg;
    assign saturated = saturated_reg;

    // Control bits of the pipeline and output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_row_end_reg <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            row_sum_reg    <= '0;
            sq_sum_reg     <= '0;
            overflow_reg   <= 1'b0;
        end
        else if (cmd.clear)
        begin
            s1_valid_reg   <= 1'b0;
            s1_row_end_reg <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            row_sum_reg    <= '0;
            sq_sum_reg     <= '0;
            overflow_reg   <= 1'b0;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
        else
        begin
            // Stage 1: product of the accepted beat
            s1_valid_reg   <= cmd.acc_valid && cmd.use_prod;
            s1_row_end_reg <= cmd.acc_valid && cmd.use_prod && cmd.row_end;

            // Stage 2: accumulate, close the row
            s2_valid_reg <= s1_valid_reg && s1_row_end_reg;
            if (s1_valid_reg)
                row_sum_reg <= s1_row_end_reg ? '0 : row_sum_new;

            // Stage 3: square
            s3_valid_reg <= s2_valid_reg;

            // Stage 4: saturating sum of squares; the root unit takes it and clears it
            if (cmd.root_start)
            begin
                sq_sum_reg   <= '0;
                overflow_reg <= 1'b0;
            end
            else if (s3_valid_reg)
            begin
                if (sq_sum_wide[mvn_pkg::SQ_SUM_W])
                begin
                    sq_sum_reg   <= '1;
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    sq_sum_reg <= sq_sum_wide[mvn_pkg::SQ_SUM_W-1:0];
                end
            end

            // Output beat handshake
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= matrix_value * vector_value;

        if (s1_valid_reg && s1_row_end_reg)
            row_val_reg <= row_sum_new[mvn_pkg::ROW_SUM_W-1:mvn_pkg::FRAC_W];

        sq_reg <= row_mag * row_mag;

        // Square root: one result bit per step
        if (cmd.root_start)
        begin
            root_work_reg <= sq_sum_reg;
            root_res_reg  <= '0;
            root_bit_reg  <= ROOT_BIT_INIT;
            sat_cap_reg   <= overflow_reg;
        end
        else if (cmd.root_step)
        begin
            if (root_fits)
            begin
                root_work_reg <= root_work_reg - root_trial;
                root_res_reg  <= (root_res_reg >> 1) + root_bit_reg;
            end
            else
            begin
                root_res_reg <= root_res_reg >> 1;
            end
            root_bit_reg <= root_bit_reg >> 2;
        end

        if (cmd.load_out)
        begin
            norm_reg      <= root_res_reg[mvn_pkg::NORM_W-1:0];
            saturated_reg <= sat_cap_reg;
        end
    end

endmodule

FILE: hdl/matrix_vector_norm_core.sv
// Top level of the matrix-vector norm: controller, datapath and port wiring.
//
// Input channel (in_valid / in_stall): one beat per matrix element in row-major
// order, matrix_value paired with the vector element of its column, both Q1.15.
// While a matrix streams in, a beat is taken every cycle. After the last beat of
// a matrix the input stalls while the multiply/accumulate/square pipeline drains
// and the root starts, the square root unit runs 32 steps (one result bit per
// step), and the root moves to the output register, which raises out_valid.
// Output channel (out_valid / out_stall): one beat per matrix carrying norm
// (Q.15 floor of the square root of the sum of squared row values) and
// saturated. The result sits in its own register, so the next matrix streams in
// while it waits; if the receiver still stalls when the next root is ready,
// the input stays stalled until the pending beat is taken.
// Configuration: cfg_write_enable writes cfg_write_data into the dimension
// register (zero acts as one, values above MAX_DIMENSION clamp) and restarts the
// current matrix. With dimension one every beat completes a matrix, norm 0.
// Reset: dimension 1000, all sums and counters zero, no output beat pending.
module matrix_vector_norm_core #(
    parameter int unsigned MAX_DIMENSION = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_enable,
    input  logic [mvn_pkg::DIM_W-1:0]           cfg_write_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [mvn_pkg::ELEM_W-1:0]   matrix_value,
    input  logic signed [mvn_pkg::ELEM_W-1:0]   vector_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mvn_pkg::NORM_W-1:0]          norm,
    output logic                                saturated
);

    mvn_pkg::mvn_cmd_t     cmd;
    mvn_pkg::mvn_status_t  status;

    // Sequencing
    mvn_ctrl #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .status           (status),
        .cmd              (cmd)
    );

    // Arithmetic
    mvn_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .matrix_value (matrix_value),
        .vector_value (vector_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .norm         (norm),
        .saturated    (saturated)
    );

endmodule

FILE: tb/tb_matrix_vector_norm_core.sv
// Testbench for matrix_vector_norm_core: random and directed matrices checked against a norm predictor.
module tb_matrix_vector_norm_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_DIM        = 1024;
    localparam int unsigned SETTLE_CYCLES  = 64;    // wait for the root after the last beat
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned PHASE_BEATS    = 100;
    localparam logic signed [mvn_pkg::ELEM_W-1:0] ELEM_MIN = 16'sh8000;
    localparam logic signed [mvn_pkg::ELEM_W-1:0] ELEM_MAX = 16'sh7fff;

    typedef struct packed {
        logic signed [mvn_pkg::ELEM_W-1:0] mat;
        logic signed [mvn_pkg::ELEM_W-1:0] vec;
    } elem_beat_t;

    typedef struct packed {
        logic [mvn_pkg::NORM_W-1:0] norm;
        logic                       sat;
    } norm_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_write_enable = 1'b0;
    logic [mvn_pkg::DIM_W-1:0]         cfg_write_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic signed [mvn_pkg::ELEM_W-1:0] matrix_value = '0;
    logic signed [mvn_pkg::ELEM_W-1:0] vector_value = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [mvn_pkg::NORM_W-1:0]        norm;
    logic                              saturated;

    matrix_vector_norm_core #(
        .MAX_DIMENSION(MAX_DIM)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_enable(cfg_write_enable),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .matrix_value    (matrix_value),
        .vector_value    (vector_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .norm            (norm),
        .saturated       (saturated)
    );

    always #5 clk = ~clk;

    // Stimulus and expectation stores
    elem_beat_t   pending_elems[$];
    norm_result_t expected_norms[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        elem_beat_taken = 1'b0;
    int unsigned fail_count = 0;
    int unsigned elem_beats = 0;
    int unsigned norms_checked = 0;
    int unsigned dim_writes = 0;
    int unsigned quiet_cycles = 0;

    // Predictor state
    logic [mvn_pkg::DIM_W-1:0]            dim_reg;
    logic signed [mvn_pkg::ROW_SUM_W-1:0] row_acc;
    logic [mvn_pkg::SQ_SUM_W-1:0]         sq_acc;
    int unsigned                          col_idx;
    int unsigned                          row_idx;
    logic                                 sat_seen;

    function automatic void clear_sums();
        row_acc  = '0;
        sq_acc   = '0;
        col_idx  = 0;
        row_idx  = 0;
        sat_seen = 1'b0;
    endfunction

    function automatic void apply_dimension(logic [mvn_pkg::DIM_W-1:0] value);
        dim_reg = value;
        clear_sums();
    endfunction

    function automatic int unsigned active_dim();
        int unsigned d;
        d = 32'(dim_reg);
        if (d == 0)
            d = 1;
        if (d > MAX_DIM)
            d = MAX_DIM;
        return d;
    endfunction

    // Floor square root, one result bit at a time from the top
    function automatic logic [mvn_pkg::NORM_W-1:0] floor_root(logic [mvn_pkg::SQ_SUM_W-1:0] x);
        logic [mvn_pkg::NORM_W-1:0] res;
        logic [mvn_pkg::NORM_W-1:0] cand;
        res = '0;
        for (int b = mvn_pkg::NORM_W - 1; b >= 0; b--)
        begin
            cand = res | (32'd1 << b);
            if (64'(cand) * 64'(cand) <= x)
                res = cand;
        end
        return res;
    endfunction

    // Fold one element into the running row and matrix sums
    function automatic void fold_element(logic signed [mvn_pkg::ELEM_W-1:0] m,
                                         logic signed [mvn_pkg::ELEM_W-1:0] v);
        int unsigned     d;
        longint          row_val;
        longint unsigned sq;
        norm_result_t    r;
        d = active_dim();
        if (d > 1)
            row_acc = row_acc + 42'(longint'(m) * longint'(v));
        if (col_idx + 1 < d)
        begin
            col_idx++;
            return;
        end
        if (d > 1)
        begin
            // floor shift to Q.15, then square the magnitude
            row_val = longint'(row_acc) >>> mvn_pkg::FRAC_W;
            if (row_val < 0)
                row_val = -row_val;
            sq = unsigned'(row_val) * unsigned'(row_val);
            if (sq_acc > ~64'd0 - sq)
            begin
                sq_acc   = '1;
                sat_seen = 1'b1;
            end
            else
                sq_acc = sq_acc + sq;
        end
        row_acc = '0;
        col_idx = 0;
        if (row_idx + 1 < d)
        begin
            row_idx++;
            return;
        end
        r.norm = floor_root(sq_acc);
        r.sat  = sat_seen;
        expected_norms.push_back(r);
        clear_sums();
    endfunction

    // Input driver: next beat once the current one is taken
    always @(negedge clk)
    begin
        elem_beat_t b;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || elem_beat_taken)
        begin
            if (pending_elems.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                b = pending_elems.pop_front();
                in_valid     <= 1'b1;
                matrix_value <= b.mat;
                vector_value <= b.vec;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver stall
    always @(negedge clk)
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);

    task automatic flag_mismatch(string what, norm_result_t want);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected norm %0d saturated %0b, got norm %0d saturated %0b",
                     $realtime, what, want.norm, want.sat, norm, saturated);
    endtask

    // Monitor: check result beats, predict from element beats
    always @(posedge clk)
    begin
        norm_result_t want;
        elem_beat_taken <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_norms.size() == 0)
                    flag_mismatch("result with none expected", '0);
                else
                begin
                    want = expected_norms.pop_front();
                    norms_checked++;
                    if (norm !== want.norm)
                        flag_mismatch("norm mismatch", want);
                    else if (saturated !== want.sat)
                        flag_mismatch("saturated mismatch", want);
                end
            end
            if (in_valid && !in_stall)
            begin
                fold_element(matrix_value, vector_value);
                elem_beats++;
            end
        end
    end

    // Watchdog on cycles without any beat or register write
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_enable)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_norms.size());
            $display("** matrix_vector_norm_core: FAILED **");
            $finish;
        end
    end

    task automatic push_elem(logic signed [mvn_pkg::ELEM_W-1:0] m,
                             logic signed [mvn_pkg::ELEM_W-1:0] v);
        elem_beat_t b;
        b.mat = m;
        b.vec = v;
        pending_elems.push_back(b);
    endtask

    function automatic logic signed [mvn_pkg::ELEM_W-1:0] rand_elem();
        case ($urandom_range(7))
            0: return ELEM_MIN;
            1: return ELEM_MAX;
            2: return 16'($signed($urandom_range(6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random(int unsigned count);
        @(posedge clk);
        for (int unsigned i = 0; i < count; i++)
            push_elem(rand_elem(), rand_elem());
    endtask

    task automatic wait_results();
        do @(posedge clk); while (pending_elems.size() != 0 || in_valid);
        do @(negedge clk); while (expected_norms.size() != 0);
    endtask

    // Block idle: all beats in, all results out, pipeline drained
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_dimension(logic [mvn_pkg::DIM_W-1:0] value);
        settle();
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        apply_dimension(value);
        dim_writes++;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    initial
    begin
        int unsigned d;
        int unsigned eff;
        int unsigned n_mats;
        int unsigned phase_beats;
        int unsigned pick;
        apply_dimension(mvn_pkg::DIM_RESET);
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Partial matrix at the reset dimension, dropped by the next write
        @(posedge clk);
        push_elem(16'sh1234, -16'sd77);
        push_elem(ELEM_MAX, ELEM_MAX);
        push_elem(ELEM_MIN, 16'sd5);

        // Dimension zero acts as one: every beat is a matrix with norm 0
        write_dimension(11'd0);
        @(posedge clk);
        push_elem(ELEM_MAX, ELEM_MIN);
        push_elem(ELEM_MIN, ELEM_MAX);

        write_dimension(11'd1);
        @(posedge clk);
        push_elem(ELEM_MIN, ELEM_MIN);
        push_elem(16'sd0, 16'sd0);

        // Largest positive products, then a negative row that floors to -1
        write_dimension(11'd2);
        @(posedge clk);
        repeat (4) push_elem(ELEM_MIN, ELEM_MIN);
        push_elem(16'sd1, -16'sd1);
        push_elem(16'sd0, 16'sd5);
        push_elem(-16'sd1, -16'sd1);
        push_elem(16'sd0, 16'sd0);
        push_elem(ELEM_MAX, ELEM_MIN);
        push_elem(ELEM_MAX, ELEM_MIN);
        push_elem(ELEM_MIN, ELEM_MAX);
        push_elem(ELEM_MAX, ELEM_MAX);

        // Oversized dimension clamps; partial matrices restarted by writes
        write_dimension(11'd2047);
        queue_random(3);
        write_dimension(11'd1024);
        queue_random(2);

        // Random phases with different idling
        for (int ph = 0; ph < 4; ph++)
        begin
            @(posedge clk);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            phase_beats = 0;
            while (phase_beats < PHASE_BEATS)
            begin
                pick = $urandom_range(15);
                if (pick == 0)
                    d = $urandom_range(1);
                else if (pick == 1)
                    d = 8;
                else
                    d = $urandom_range(5, 2);
                write_dimension(mvn_pkg::DIM_W'(d));
                eff    = (d == 0) ? 1 : d;
                n_mats = $urandom_range(4, 1);
                for (int unsigned k = 0; k < n_mats; k++)
                begin
                    queue_random(eff * eff);
                    phase_beats += eff * eff;
                    // sender holds off until the last norm is back
                    if (ph == 1)
                        wait_results();
                end
                // broken matrix, cleared by the next dimension write
                if (eff > 1 && $urandom_range(5) == 0)
                    queue_random($urandom_range(eff * eff - 1, 1));
            end
        end

        settle();
        fail_count += expected_norms.size();
        $display("Covered %0d element beats, %0d norms checked, %0d dimension writes",
                 elem_beats, norms_checked, dim_writes);
        $display("Dimensions 0, 1, 2 to 5 and 8, partial matrices at 1000, 1024 and 2047; "
                 , "idling none, sender, receiver, both");
        if (fail_count == 0)
            $display("** matrix_vector_norm_core: PASSED **");
        else
            $display("** matrix_vector_norm_core: FAILED **");
        $finish;
    end

endmodule
